// ----- sv/escdfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escdfr_pkg
// Types and constants shared by the ESC/STX deframer with rollback.
// ----------------------------------------------------------------------------
package escdfr_pkg;

    localparam int unsigned HEADER_BYTES = 8;

    localparam logic [7:0] ESC_BYTE     = 8'd27;
    localparam logic [7:0] STX_BYTE     = 8'd3;
    localparam logic [7:0] UNKNOWN_SEQ  = 8'd255;
    localparam int unsigned INHIBIT_POS = 7;

    localparam logic [10:0] HEADER_LEN  = 11'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROLLBACK_OFF  = 2'd0;
    localparam logic [1:0] CFG_HOLDOFF_TICKS = 2'd1;
    localparam logic [1:0] CFG_WAIT_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_MAX_LENGTH    = 2'd3;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_ROLLBACK  = 2'd1;
    localparam logic [1:0] KIND_KEEPALIVE = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FWD_NONE = 2'd0,
        FWD_BODY = 2'd1,
        FWD_HEAD = 2'd2
    } fwd_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic        rollback_off;
        logic [15:0] holdoff_ticks;
        logic [7:0]  wait_limit;
        logic [10:0] max_length;
    } cfg_t;

    // One queued command: everything one input request emits.
    typedef struct packed {
        logic                          keep;
        logic [1:0]                    nreq;
        logic [7:0]                    req_val;
        logic [7:0]                    req_last_val;
        fwd_t                          fwd;
        logic                          last;
        logic [HEADER_BYTES-1:0][7:0]  data;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/escdfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escdfr_front
// Parses link bytes and ticks, keeps the link state and issues commands.
// ----------------------------------------------------------------------------
module escdfr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire escdfr_pkg::cfg_t   cfg,
    input  wire logic               accept,
    input  wire escdfr_pkg::in_item_t item,
    output escdfr_pkg::cmd_t        cmd,
    output logic                    push
);
    import escdfr_pkg::*;

    phase_t                        phase_reg, phase_next;
    logic                          saw_esc_reg, saw_esc_next;
    logic [HEADER_BYTES-1:0][7:0]  hdr_reg, hdr_next;
    logic [10:0]                   idx_reg, idx_next;
    logic [10:0]                   len_reg, len_next;
    logic [7:0]                    seq_reg, seq_next;
    logic                          known_reg, known_next;
    logic [7:0]                    wait_reg, wait_next;
    logic                          fwd_reg, fwd_next;
    logic [15:0]                   hold_reg, hold_next;

    logic [HEADER_BYTES-1:0][7:0]  hv;
    logic [7:0]                    b;
    logic                          leads_ok;
    logic                          inh;
    logic [10:0]                   len;
    logic                          do_complete;
    logic                          cmp_fw;
    logic [8:0]                    cnt;
    logic [1:0]                    nreq;
    logic                          end_req;
    logic [7:0]                    pre_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            saw_esc_reg <= 1'b0;
            idx_reg     <= '0;
            len_reg     <= '0;
            seq_reg     <= '0;
            known_reg   <= 1'b0;
            wait_reg    <= 8'd1;
            fwd_reg     <= 1'b0;
            hold_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            saw_esc_reg <= saw_esc_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            seq_reg     <= seq_next;
            known_reg   <= known_next;
            wait_reg    <= wait_next;
            fwd_reg     <= fwd_next;
            hold_reg    <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        saw_esc_next = saw_esc_reg;
        hdr_next     = hdr_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        seq_next     = seq_reg;
        known_next   = known_reg;
        wait_next    = wait_reg;
        fwd_next     = fwd_reg;
        hold_next    = hold_reg;
        b            = item.rx_byte;
        hv           = hdr_reg;
        leads_ok     = 1'b0;
        inh          = 1'b0;
        len          = '0;
        do_complete  = 1'b0;
        cmp_fw       = 1'b0;
        cnt          = '0;
        nreq         = '0;
        end_req      = 1'b0;
        pre_val      = '0;
        cmd          = '0;
        cmd.fwd      = FWD_NONE;

        if (accept && item.opcode == OP_TICK)
        begin
            if (hold_reg != '0)
                hold_next = hold_reg - 16'd1;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    hv[idx_reg[2:0]]       = b;
                    hdr_next[idx_reg[2:0]] = b;
                    idx_next               = idx_reg + 11'd1;
                    if (idx_next >= HEADER_LEN)
                    begin
                        idx_next = '0;
                        leads_ok = (hv[0] == ESC_BYTE) && (hv[1] == STX_BYTE);
                        if (leads_ok && hv[2] == 8'd8 && hv[3] == 8'd0 && hv[4] == 8'd1)
                        begin
                            phase_next = PH_HEAD;
                            cmd.keep   = 1'b1;
                        end
                        else if (!leads_ok)
                        begin
                            phase_next   = PH_HUNT;
                            saw_esc_next = (hv[7] == ESC_BYTE);
                            if (!cfg.rollback_off && hold_next == '0)
                            begin
                                nreq      = nreq + 2'd1;
                                hold_next = cfg.holdoff_ticks;
                            end
                            wait_next = 8'd1;
                        end
                        else
                        begin
                            inh = hv[3][INHIBIT_POS];
                            if (!known_next)
                            begin
                                seq_next   = hv[7] - 8'd1;
                                known_next = 1'b1;
                            end
                            if ((seq_next + 8'd1) != hv[7] && !inh)
                            begin
                                if (!cfg.rollback_off && hold_next == '0)
                                begin
                                    nreq      = nreq + 2'd1;
                                    hold_next = cfg.holdoff_ticks;
                                end
                                wait_next = 8'd1;
                            end
                            len = {hv[3][2:0], hv[2]};
                            if (len == HEADER_LEN && hv[4] == 8'd0)
                            begin
                                // Partner asks us to roll back.
                                if (!cfg.rollback_off && hold_next == '0)
                                begin
                                    nreq      = nreq + 2'd1;
                                    hold_next = cfg.holdoff_ticks;
                                end
                                wait_next  = 8'd1;
                                phase_next = PH_HEAD;
                            end
                            else if (len < HEADER_LEN || len > cfg.max_length)
                            begin
                                if (!cfg.rollback_off && hold_next == '0)
                                begin
                                    nreq      = nreq + 2'd1;
                                    hold_next = cfg.holdoff_ticks;
                                end
                                wait_next    = 8'd1;
                                phase_next   = PH_HUNT;
                                saw_esc_next = 1'b0;
                            end
                            else
                            begin
                                len_next = len;
                                if (wait_next != '0 && (inh || cfg.rollback_off))
                                    wait_next = '0;
                                cmp_fw = (wait_next == '0);
                                if (cmp_fw)
                                begin
                                    cmd.fwd  = FWD_HEAD;
                                    cmd.data = hv;
                                    cmd.last = (len == HEADER_LEN);
                                end
                                if (len == HEADER_LEN)
                                begin
                                    do_complete = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                    idx_next   = HEADER_LEN;
                                    fwd_next   = cmp_fw;
                                end
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    idx_next = idx_reg + 11'd1;
                    if (fwd_reg)
                    begin
                        cmd.fwd     = FWD_BODY;
                        cmd.data[0] = b;
                        cmd.last    = (idx_next >= len_reg);
                    end
                    if (idx_next >= len_reg)
                    begin
                        do_complete = 1'b1;
                        cmp_fw      = fwd_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (saw_esc_reg && b == STX_BYTE)
                    begin
                        hdr_next[0]  = ESC_BYTE;
                        hdr_next[1]  = STX_BYTE;
                        idx_next     = 11'd2;
                        saw_esc_next = 1'b0;
                        phase_next   = PH_HEAD;
                    end
                    else
                    begin
                        saw_esc_next = (b == ESC_BYTE);
                    end
                end
            endcase

            pre_val = known_next ? seq_next : UNKNOWN_SEQ;

            if (do_complete)
            begin
                if (cmp_fw)
                begin
                    seq_next   = hv[7];
                    known_next = 1'b1;
                end
                else
                begin
                    cnt = {1'b0, wait_next} + 9'd1;
                    if (cnt > {1'b0, cfg.wait_limit})
                    begin
                        cnt        = '0;
                        seq_next   = hv[7];
                        known_next = 1'b1;
                    end
                    wait_next = cnt[7:0];
                    if (!cfg.rollback_off && hold_next == '0)
                    begin
                        nreq      = nreq + 2'd1;
                        hold_next = cfg.holdoff_ticks;
                        end_req   = 1'b1;
                    end
                end
                phase_next = PH_HEAD;
                idx_next   = '0;
                fwd_next   = 1'b0;
            end
        end

        // A request raised at the end of a packet carries the sequence as it
        // stands after the wait check; earlier ones carry it from before that check.
        cmd.nreq         = nreq;
        cmd.req_val      = pre_val;
        cmd.req_last_val = end_req ? (known_next ? seq_next : UNKNOWN_SEQ) : pre_val;
        push = accept && item.opcode == OP_BYTE
               && (cmd.keep || nreq != '0 || cmd.fwd != FWD_NONE);
    end

endmodule
`default_nettype wire

// ----- sv/escdfr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escdfr_queue
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module escdfr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire escdfr_pkg::cmd_t push_cmd,
    input  wire logic             pop,
    output escdfr_pkg::cmd_t      head_cmd,
    output logic                  not_empty,
    output logic                  full
);
    import escdfr_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    assign head_cmd  = entry_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(DEPTH));

endmodule
`default_nettype wire

// ----- sv/escdfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escdfr_back
// Expands each queued command into result items, one per unstalled cycle.
// ----------------------------------------------------------------------------
module escdfr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire escdfr_pkg::cmd_t head_cmd,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output escdfr_pkg::out_item_t out_item
);
    import escdfr_pkg::*;

    logic        valid_reg, valid_next;
    out_item_t   item_reg, item_next;
    logic [3:0]  ptr_reg, ptr_next;

    logic [3:0]  nbytes;
    logic [3:0]  total;
    logic [3:0]  j;
    logic        load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        case (head_cmd.fwd)
            FWD_HEAD: nbytes = 4'(HEADER_BYTES);
            FWD_BODY: nbytes = 4'd1;
            default:  nbytes = 4'd0;
        endcase
        total = head_cmd.keep ? 4'd1 : ({2'b00, head_cmd.nreq} + nbytes);
        j     = ptr_reg - {2'b00, head_cmd.nreq};
        load  = head_valid && (!valid_reg || !out_stall);
        pop   = load && (ptr_reg == total - 4'd1);

        item_next  = item_reg;
        valid_next = valid_reg && out_stall;
        ptr_next   = ptr_reg;
        if (load)
        begin
            valid_next = 1'b1;
            ptr_next   = pop ? '0 : ptr_reg + 4'd1;
            if (head_cmd.keep)
            begin
                item_next.kind  = KIND_KEEPALIVE;
                item_next.value = '0;
                item_next.last  = 1'b0;
            end
            else if (ptr_reg < {2'b00, head_cmd.nreq})
            begin
                item_next.kind  = KIND_ROLLBACK;
                item_next.value = (ptr_reg == {2'b00, head_cmd.nreq} - 4'd1)
                                  ? head_cmd.req_last_val : head_cmd.req_val;
                item_next.last  = 1'b0;
            end
            else
            begin
                item_next.kind  = KIND_BYTE;
                item_next.value = head_cmd.data[j[2:0]];
                item_next.last  = head_cmd.last && (j == nbytes - 4'd1);
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- sv/escstx_packet_deframer_with_rollback_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escstx_packet_deframer_with_rollback_unit
// ESC/STX packet deframer with sequence checks and rollback requests.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_stall  | in_item (opcode, rx_byte)
//  out     | output    | out_valid/ out_stall | out_item (kind, value, last)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  A request is parsed in the cycle it is accepted; its results (up to eight)
//  leave one per cycle through a registered output while out_stall is low, so
//  input rate is one request per cycle except while a longer command drains.
//  The command queue (QUEUE_DEPTH entries) holds in_stall high when full.
//  Reset puts the link into hunting with the documented register defaults.
// ----------------------------------------------------------------------------
module escstx_packet_deframer_with_rollback_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire escdfr_pkg::in_item_t   in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output escdfr_pkg::out_item_t       out_item,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data
);
    import escdfr_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  push_cmd;
    cmd_t  head_cmd;
    logic  push;
    logic  pop;
    logic  head_valid;
    logic  q_full;
    logic  accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rollback_off  <= 1'b0;
            cfg_reg.holdoff_ticks <= 16'd2;
            cfg_reg.wait_limit    <= 8'd50;
            cfg_reg.max_length    <= 11'd2047;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROLLBACK_OFF:  cfg_reg.rollback_off  <= cfg_data[0];
                CFG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks <= cfg_data;
                CFG_WAIT_LIMIT:    cfg_reg.wait_limit    <= cfg_data[7:0];
                CFG_MAX_LENGTH:    cfg_reg.max_length    <= cfg_data[10:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    escdfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .item   (in_item),
        .cmd    (push_cmd),
        .push   (push)
    );

    escdfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (head_valid),
        .full      (q_full)
    );

    escdfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule
`default_nettype wire

// ----- tb/escdfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escdfr_checker
// Watches the request, result and register ports of the deframer, predicts
// every result from the accepted requests and compares them in order.
// ----------------------------------------------------------------------------
module escdfr_checker
    import escdfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_stall,
    input  wire in_item_t  in_item,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_item_t out_item,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    output int             fail_count,
    output int             pending
);

    // Register copies, reset values as in the block.
    logic        r_off;
    logic [15:0] r_holdoff;
    logic [7:0]  r_wait_limit;
    logic [10:0] r_max_len;

    // Link state of the deframer.
    phase_t      phase;
    logic        esc_seen;
    logic [7:0]  hdr [HEADER_BYTES];
    logic [10:0] idx;
    logic [10:0] pkt_len;
    logic [7:0]  last_seq;
    logic        seq_known;
    logic [7:0]  wait_cnt;
    logic        fwd_on;
    logic [15:0] hold_cnt;

    out_item_t   expected_q[$];
    int          mismatches;

    assign pending    = expected_q.size();
    assign fail_count = mismatches;

    function automatic out_item_t mk(logic [1:0] k, logic [7:0] v, logic l);
        out_item_t o;
        o.kind  = k;
        o.value = v;
        o.last  = l;
        return o;
    endfunction

    task automatic request_rollback();
        if (!r_off && hold_cnt == 0)
        begin
            hold_cnt = r_holdoff;
            expected_q.push_back(mk(KIND_ROLLBACK, seq_known ? last_seq : UNKNOWN_SEQ, 1'b0));
        end
    endtask

    task automatic end_of_packet();
        int cnt;
        if (fwd_on)
        begin
            last_seq  = hdr[7];
            seq_known = 1'b1;
        end
        else
        begin
            cnt = int'(wait_cnt) + 1;
            if (cnt > int'(r_wait_limit))
            begin
                cnt       = 0;
                last_seq  = hdr[7];
                seq_known = 1'b1;
            end
            wait_cnt = cnt[7:0];
            request_rollback();
        end
        phase  = PH_HEAD;
        idx    = '0;
        fwd_on = 1'b0;
    endtask

    task automatic header_complete();
        logic        leads_ok;
        logic        inh;
        logic [10:0] len;
        leads_ok = hdr[0] == ESC_BYTE && hdr[1] == STX_BYTE;
        idx = '0;
        if (leads_ok && hdr[2] == 8'd8 && hdr[3] == 8'd0 && hdr[4] == 8'd1)
        begin
            phase = PH_HEAD;
            expected_q.push_back(mk(KIND_KEEPALIVE, 8'd0, 1'b0));
            return;
        end
        if (!leads_ok)
        begin
            phase    = PH_HUNT;
            esc_seen = hdr[7] == ESC_BYTE;
            request_rollback();
            wait_cnt = 8'd1;
            return;
        end
        inh = hdr[3][INHIBIT_POS];
        if (!seq_known)
        begin
            last_seq  = hdr[7] - 8'd1;
            seq_known = 1'b1;
        end
        if (last_seq + 8'd1 != hdr[7] && !inh)
        begin
            request_rollback();
            wait_cnt = 8'd1;
        end
        len = {hdr[3][2:0], hdr[2]};
        if (len == HEADER_LEN && hdr[4] == 8'd0)
        begin
            request_rollback();
            wait_cnt = 8'd1;
            phase    = PH_HEAD;
            return;
        end
        if (len < HEADER_LEN || len > r_max_len)
        begin
            request_rollback();
            wait_cnt = 8'd1;
            phase    = PH_HUNT;
            esc_seen = 1'b0;
            return;
        end
        pkt_len = len;
        if (wait_cnt != 0 && (inh || r_off))
            wait_cnt = 8'd0;
        fwd_on = wait_cnt == 0;
        if (fwd_on)
            for (int i = 0; i < HEADER_BYTES; i++)
                expected_q.push_back(mk(KIND_BYTE, hdr[i],
                    i == HEADER_BYTES - 1 && len == HEADER_LEN));
        if (len == HEADER_LEN)
        begin
            end_of_packet();
            return;
        end
        phase = PH_BODY;
        idx   = 11'(HEADER_BYTES);
    endtask

    task automatic predict_request(in_item_t it);
        if (it.opcode == OP_TICK)
        begin
            if (hold_cnt != 0)
                hold_cnt--;
            return;
        end
        if (phase == PH_HEAD)
        begin
            hdr[idx[2:0]] = it.rx_byte;
            idx++;
            if (idx >= HEADER_BYTES)
                header_complete();
        end
        else if (phase == PH_BODY)
        begin
            idx++;
            if (fwd_on)
                expected_q.push_back(mk(KIND_BYTE, it.rx_byte, idx >= pkt_len));
            if (idx >= pkt_len)
                end_of_packet();
        end
        else
        begin
            phase = PH_HUNT;
            if (esc_seen && it.rx_byte == STX_BYTE)
            begin
                hdr[0]   = ESC_BYTE;
                hdr[1]   = STX_BYTE;
                idx      = 11'd2;
                esc_seen = 1'b0;
                phase    = PH_HEAD;
            end
            else
                esc_seen = it.rx_byte == ESC_BYTE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_off        = 1'b0;
            r_holdoff    = 16'd2;
            r_wait_limit = 8'd50;
            r_max_len    = 11'd2047;
            phase        = PH_HUNT;
            esc_seen     = 1'b0;
            idx          = '0;
            pkt_len      = '0;
            last_seq     = '0;
            seq_known    = 1'b0;
            wait_cnt     = 8'd1;
            fwd_on       = 1'b0;
            hold_cnt     = '0;
            for (int i = 0; i < HEADER_BYTES; i++)
                hdr[i] = '0;
            expected_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_ROLLBACK_OFF:  r_off        = cfg_data[0];
                    CFG_HOLDOFF_TICKS: r_holdoff    = cfg_data;
                    CFG_WAIT_LIMIT:    r_wait_limit = cfg_data[7:0];
                    CFG_MAX_LENGTH:    r_max_len    = cfg_data[10:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict_request(in_item);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d value %0d last %0d",
                                 out_item.kind, out_item.value, out_item.last);
                end
                else
                begin
                    if (out_item !== expected_q[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
                                     expected_q[0].kind, expected_q[0].value,
                                     expected_q[0].last, out_item.kind,
                                     out_item.value, out_item.last);
                    end
                    void'(expected_q.pop_front());
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed link traffic, ticks and noise into the deframer under several
// register settings, with random idling on both sides; the checker predicts.
// ----------------------------------------------------------------------------
module testbench;
    import escdfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    logic        idle_on;
    logic [7:0]  next_seq;

    escstx_packet_deframer_with_rollback_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    escdfr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= idle_on ? ($urandom_range(99) < 31) : 1'b0;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(logic op, logic [7:0] b);
        in_item_t it;
        while (idle_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.opcode  = op;
        it.rx_byte = b;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        drain();
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(logic off, logic [15:0] hold, logic [7:0] wl, logic [10:0] ml);
        write_reg(CFG_ROLLBACK_OFF, {15'd0, off});
        write_reg(CFG_HOLDOFF_TICKS, hold);
        write_reg(CFG_WAIT_LIMIT, {8'd0, wl});
        write_reg(CFG_MAX_LENGTH, {5'd0, ml});
    endtask

    // One framed packet; the lead-in pair is sent only when sync is wanted.
    task automatic send_packet(logic [10:0] len, logic inh, logic [7:0] fmt,
                               logic [7:0] seq, logic leads);
        logic [7:0] b3;
        b3 = {inh, 4'($urandom), len[10:8]};
        if (leads)
        begin
            send(OP_BYTE, ESC_BYTE);
            send(OP_BYTE, STX_BYTE);
        end
        send(OP_BYTE, len[7:0]);
        send(OP_BYTE, b3);
        send(OP_BYTE, fmt);
        send(OP_BYTE, 8'($urandom));
        send(OP_BYTE, 8'($urandom));
        send(OP_BYTE, seq);
        for (int i = HEADER_BYTES; i < int'(len); i++)
            send(OP_BYTE, 8'($urandom));
    endtask

    task automatic random_traffic(int nbytes, logic [10:0] top_len);
        int sent;
        int r;
        logic [10:0] len;
        sent = 0;
        while (sent < nbytes)
        begin
            r = $urandom_range(99);
            len = ($urandom_range(19) == 0) ? 11'($urandom_range(top_len, 8))
                                            : 11'($urandom_range(24, 8));
            if (r < 55)
            begin
                send_packet(len, $urandom_range(99) < 15, 8'($urandom_range(255, 1)),
                            next_seq, 1'b1);
                next_seq++;
                sent += len;
            end
            else if (r < 61)
            begin
                send_packet(11'd8, 1'b0, 8'd1, 8'($urandom), 1'b1);
                sent += 8;
            end
            else if (r < 66)
            begin
                send_packet(11'd8, 1'b0, 8'd0, next_seq, 1'b1);
                sent += 8;
            end
            else if (r < 71)
            begin
                send_packet(11'($urandom_range(7)), 1'b0, 8'd2, next_seq, 1'b1);
                sent += 8;
            end
            else if (r < 78)
            begin
                send_packet(len, $urandom_range(1), 8'd5, 8'($urandom), 1'b1);
                sent += len;
            end
            else if (r < 86)
            begin
                repeat ($urandom_range(5, 1)) send(OP_TICK, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    send(OP_BYTE, $urandom_range(3) == 0 ? ESC_BYTE : 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ROLLBACK_OFF;
        cfg_data  = '0;
        idle_on   = 1'b1;
        next_seq  = 8'd10;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise, a double escape, a keepalive unless byte 3's random bits are set,
        // inhibited packet, partner request, bad length, out of sequence and bad lead-ins.
        send(OP_BYTE, 8'hFF);
        send(OP_BYTE, ESC_BYTE);
        send(OP_TICK, 8'h00);
        send(OP_BYTE, ESC_BYTE);
        send(OP_BYTE, STX_BYTE);
        send_packet(11'd8, 1'b0, 8'd1, 8'd0, 1'b0);
        send_packet(11'd9, 1'b1, 8'hFF, 8'd9, 1'b1);
        send_packet(11'd8, 1'b0, 8'd0, 8'd10, 1'b1);
        send(OP_TICK, 8'hFF);
        send(OP_TICK, 8'h00);
        send_packet(11'd0, 1'b0, 8'd3, 8'd10, 1'b1);
        send(OP_BYTE, ESC_BYTE);
        send(OP_BYTE, STX_BYTE);
        send_packet(11'd8, 1'b1, 8'd3, 8'd11, 1'b0);
        send_packet(11'd8, 1'b0, 8'd3, 8'd40, 1'b1);
        send_packet(11'd8, 1'b0, 8'd3, ESC_BYTE, 1'b0);
        send(OP_BYTE, STX_BYTE);
        next_seq = 8'd12;

        random_traffic(10, 11'd24);
        drain();

        set_regs(1'b1, 16'd0, 8'd1, 11'd8);
        random_traffic(6, 11'd8);

        set_regs(1'b0, 16'hFFFF, 8'd255, 11'd2047);
        idle_on = 1'b0;
        send_packet(11'd16, 1'b1, 8'd7, next_seq, 1'b1);
        next_seq++;
        random_traffic(6, 11'd24);
        idle_on = 1'b1;

        set_regs(1'b0, 16'd0, 8'd1, 11'd40);
        random_traffic(8, 11'd24);

        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
